// ===== hw/rtl/bba_pkg.sv =====
// Shared types, codes and helpers for the bitmap block allocator.
package bba_pkg;

   localparam int unsigned BLK_W     = 14;
   localparam int unsigned CNT_W     = 15;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned BIT_W     = 5;
   localparam int unsigned WIDX_W    = CNT_W - BIT_W;
   localparam int unsigned FUNC_W    = 2;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned COUNT_MAX = 32767;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FORMAT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLK_TOTAL  = 1'd1;

   typedef struct packed {
      logic [BLK_W-1:0]    granted_block;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } hit_type;

   // lowest set bit of a map word
   function automatic hit_type find_first(input logic [WORD_W-1:0] w);
      hit_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            r.found = 1'b1;
            r.idx   = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/bba_if.sv =====
// Request and response channel interfaces of the block allocator.
interface bba_req_if;
   logic                            valid;
   logic                            ready;
   logic [bba_pkg::FUNC_W-1:0]      func;
   logic [bba_pkg::BLK_W-1:0]       block_number;
   modport source (output valid, func, block_number, input ready);
   modport sink   (input valid, func, block_number, output ready);
endinterface

interface bba_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bba_pkg::BLK_W-1:0]       granted_block;
   logic [bba_pkg::STATUS_W-1:0]    status;
   logic [bba_pkg::CNT_W-1:0]       free_count;
   modport source (output valid, granted_block, status, free_count, input ready);
   modport sink   (input valid, granted_block, status, free_count, output ready);
endinterface

// ===== hw/rtl/bba_map_ram.sv =====
// Used-bit map storage: one write port, one registered read port.
module bba_map_ram #(
   parameter int unsigned DEPTH = 512,
   parameter int unsigned AW    = 9
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [bba_pkg::WORD_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bba_pkg::WORD_W-1:0]  wr_data
);

   logic [bba_pkg::WORD_W-1:0] mem [DEPTH];
   logic [bba_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bba_engine.sv =====
// Sequencer: format sweep, first-fit word scan and free read-modify-write.
module bba_engine #(
   parameter int unsigned MAX_BLOCKS = 16384
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [bba_pkg::CNT_W-1:0]            data_start,
   input  logic [bba_pkg::CNT_W-1:0]            blk_total,
   input  logic                                 req_valid,
   input  logic [bba_pkg::FUNC_W-1:0]           req_func,
   input  logic [bba_pkg::BLK_W-1:0]            req_block,
   output logic                                 req_ready,
   output logic                                 res_valid,
   output bba_pkg::rsp_type                     res,
   input  logic                                 res_ready,
   output logic                                 rd_en,
   output logic [$clog2((MAX_BLOCKS+31)/32)-1:0] rd_addr,
   input  logic [bba_pkg::WORD_W-1:0]           rd_data,
   output logic                                 wr_en,
   output logic [$clog2((MAX_BLOCKS+31)/32)-1:0] wr_addr,
   output logic [bba_pkg::WORD_W-1:0]           wr_data
);

   localparam int unsigned WORDS   = (MAX_BLOCKS + 31) / 32;
   localparam int unsigned AW      = $clog2(WORDS);
   localparam int unsigned T_CLAMP =
      (MAX_BLOCKS > bba_pkg::COUNT_MAX) ? bba_pkg::COUNT_MAX : MAX_BLOCKS;
   localparam logic [bba_pkg::CNT_W-1:0] T_LIMIT   = bba_pkg::CNT_W'(T_CLAMP);
   localparam logic [bba_pkg::CNT_W-1:0] CNT_SAT   = bba_pkg::CNT_W'(bba_pkg::COUNT_MAX);
   localparam logic [AW-1:0]             LAST_WORD = AW'(WORDS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ACHK = 3'd1;
   localparam logic [2:0] S_FCHK = 3'd2;
   localparam logic [2:0] S_FMT  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [bba_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             fmt_ok_ff, fmt_ok_in;
   logic [bba_pkg::CNT_W-1:0]        s_ff, s_in;
   logic [bba_pkg::CNT_W-1:0]        t_ff, t_in;
   logic [bba_pkg::WIDX_W-1:0]       word_ff, word_in;
   logic [bba_pkg::BIT_W-1:0]        bit_ff, bit_in;
   logic [AW-1:0]                    fw_ff, fw_in;
   bba_pkg::rsp_type                 res_ff, res_in;

   logic [bba_pkg::CNT_W-1:0]        t_eff, s_eff, t_last, cnt_up;
   logic [bba_pkg::WIDX_W-1:0]       s_word, last_word;
   logic [bba_pkg::WORD_W-1:0]       lo_mask, hi_mask, avail, fmt_word;
   logic [bba_pkg::CNT_W-1:0]        grant_full;
   bba_pkg::hit_type                 hit;
   logic                             accept;

   assign t_eff     = (blk_total < T_LIMIT) ? blk_total : T_LIMIT;
   assign s_eff     = (data_start < t_eff) ? data_start : t_eff;
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

   assign t_last    = t_ff - 15'd1;
   assign last_word = t_last[bba_pkg::CNT_W-1:bba_pkg::BIT_W];
   assign s_word    = s_ff[bba_pkg::CNT_W-1:bba_pkg::BIT_W];

   // blocks below data start or at/after total are treated as taken
   assign lo_mask = (word_ff == s_word) ?
                    ((32'd1 << s_ff[bba_pkg::BIT_W-1:0]) - 32'd1) : '0;
   assign hi_mask = (word_ff == last_word) ?
                    ~(32'hFFFF_FFFF >> (5'd31 - t_last[bba_pkg::BIT_W-1:0])) : '0;
   assign avail   = ~(rd_data | lo_mask | hi_mask);
   assign hit     = bba_pkg::find_first(avail);
   assign grant_full = {word_ff, hit.idx};
   assign cnt_up  = (cnt_ff < CNT_SAT) ? cnt_ff + 15'd1 : cnt_ff;

   always_comb begin
      if (32'(fw_ff) < 32'(s_word)) begin
         fmt_word = '1;
      end else if (32'(fw_ff) == 32'(s_word)) begin
         fmt_word = (32'd1 << s_ff[bba_pkg::BIT_W-1:0]) - 32'd1;
      end else begin
         fmt_word = '0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      fmt_ok_in = fmt_ok_ff;
      s_in      = s_ff;
      t_in      = t_ff;
      word_in   = word_ff;
      bit_in    = bit_ff;
      fw_in     = fw_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_addr   = AW'(word_ff);
      wr_en     = 1'b0;
      wr_addr   = AW'(word_ff);
      wr_data   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               s_in                 = s_eff;
               t_in                 = t_eff;
               res_in.granted_block = '0;
               res_in.status        = bba_pkg::STATUS_OK;
               res_in.free_count    = cnt_ff;
               case (req_func)
                  bba_pkg::FUNC_ALLOC: begin
                     if (cnt_ff == '0 || s_eff >= t_eff) begin
                        res_in.status = bba_pkg::STATUS_NOSPACE;
                        state_in      = S_RESP;
                     end else begin
                        word_in  = s_eff[bba_pkg::CNT_W-1:bba_pkg::BIT_W];
                        rd_en    = 1'b1;
                        rd_addr  = AW'(s_eff[bba_pkg::CNT_W-1:bba_pkg::BIT_W]);
                        state_in = S_ACHK;
                     end
                  end
                  bba_pkg::FUNC_FREE: begin
                     if (fmt_ok_ff && ({1'b0, req_block} < t_eff)) begin
                        word_in  = {1'b0, req_block[bba_pkg::BLK_W-1:bba_pkg::BIT_W]};
                        bit_in   = req_block[bba_pkg::BIT_W-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_block[bba_pkg::BLK_W-1:bba_pkg::BIT_W]);
                        state_in = S_FCHK;
                     end else begin
                        res_in.status = bba_pkg::STATUS_IGNORED;
                        state_in      = S_RESP;
                     end
                  end
                  bba_pkg::FUNC_FORMAT: begin
                     fmt_ok_in = 1'b1;
                     cnt_in    = t_eff - s_eff;
                     fw_in     = '0;
                     state_in  = S_FMT;
                  end
                  default: begin
                     res_in.status = bba_pkg::STATUS_IGNORED;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end
         S_ACHK: begin
            if (hit.found) begin
               wr_en                = 1'b1;
               wr_data              = rd_data | (32'd1 << hit.idx);
               cnt_in               = cnt_ff - 15'd1;
               res_in.granted_block = grant_full[bba_pkg::BLK_W-1:0];
               res_in.status        = bba_pkg::STATUS_OK;
               res_in.free_count    = cnt_ff - 15'd1;
               state_in             = S_RESP;
            end else if (word_ff == last_word) begin
               res_in.status = bba_pkg::STATUS_NOSPACE;
               state_in      = S_RESP;
            end else begin
               // fetch the next word while this one is checked
               word_in = word_ff + 10'd1;
               rd_en   = 1'b1;
               rd_addr = AW'(word_ff + 10'd1);
            end
         end
         S_FCHK: begin
            if (rd_data[bit_ff]) begin
               wr_en             = 1'b1;
               wr_data           = rd_data & ~(32'd1 << bit_ff);
               cnt_in            = cnt_up;
               res_in.free_count = cnt_up;
            end else begin
               res_in.status = bba_pkg::STATUS_IGNORED;
            end
            state_in = S_RESP;
         end
         S_FMT: begin
            wr_en   = 1'b1;
            wr_addr = fw_ff;
            wr_data = fmt_word;
            if (fw_ff == LAST_WORD) begin
               res_in.free_count = cnt_ff;
               state_in          = S_RESP;
            end else begin
               fw_in = fw_ff + AW'(1);
            end
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         fmt_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         fmt_ok_ff <= fmt_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      t_ff    <= t_in;
      word_ff <= word_in;
      bit_ff  <= bit_in;
      fw_ff   <= fw_in;
      res_ff  <= res_in;
   end

   a_one_bit_changed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACHK || state_ff == S_FCHK) && wr_en
      |-> $countones(wr_data ^ rd_data) == 1)
      else $error("map update changes other than one bit");

   a_alloc_counts_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACHK) && hit.found |=> cnt_ff == $past(cnt_ff) - 15'd1)
      else $error("grant without count decrement");

   a_grant_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status != bba_pkg::STATUS_OK) |-> res.granted_block == '0)
      else $error("nonzero granted block on failed request");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FMT) && (fw_ff == LAST_WORD) |=> state_ff == S_RESP)
      else $error("format sweep did not finish at last word");

endmodule

// ===== hw/rtl/bitmap_block_allocator_core.sv =====
// Bitmap first-fit block allocator: one request accepted at a time, one response per request.
// Allocate scans map words first-fit from the data start word to the last block's word; free
// clears the block's bit, if set, after a map read; format writes all map words, one map word per cycle.
// Allocate with nothing to search, an out-of-range or unformatted free and func 3 skip the map.
// The next request transfers in the cycle its response appears, whether or not that response stalls.
// Reset clears the free count, marks the map unformatted, loads data start 1 and total 16384.
module bitmap_block_allocator_core #(
   parameter int unsigned MAX_BLOCKS = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   bba_req_if.sink                            req_ch,
   bba_rsp_if.source                          rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [bba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bba_pkg::CNT_W-1:0]          csr_wr_data
);

   localparam int unsigned WORDS = (MAX_BLOCKS + 31) / 32;
   localparam int unsigned AW    = $clog2(WORDS);

   logic [bba_pkg::CNT_W-1:0]  ds_ff, ds_in;
   logic [bba_pkg::CNT_W-1:0]  tot_ff, tot_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                       res_valid, res_ready;
   bba_pkg::rsp_type           res;
   logic                       rd_en, wr_en;
   logic [AW-1:0]              rd_addr, wr_addr;
   logic [bba_pkg::WORD_W-1:0] rd_data, wr_data;

   bba_engine #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .data_start   (ds_ff),
      .blk_total    (tot_ff),
      .req_valid    (req_ch.valid),
      .req_func     (req_ch.func),
      .req_block    (req_ch.block_number),
      .req_ready    (req_ch.ready),
      .res_valid    (res_valid),
      .res          (res),
      .res_ready    (res_ready),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   bba_map_ram #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      ds_in  = ds_ff;
      tot_in = tot_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bba_pkg::CSR_DATA_START: ds_in  = csr_wr_data;
            bba_pkg::CSR_BLK_TOTAL:  tot_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // output register: loads when empty or when its transfer completes
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff        <= 15'd1;
         tot_ff       <= 15'd16384;
         rsp_valid_ff <= 1'b0;
      end else begin
         ds_ff        <= ds_in;
         tot_ff       <= tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.granted_block = rsp_data_ff.granted_block;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.free_count    = rsp_data_ff.free_count;

endmodule
